[design/ccd_pkg.sv]
// shared constants and types of the comma code decoder
package ccd_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int WORD_BITS   = 32;
   localparam int OUT_BITS    = 32;
   localparam int DIGIT_BITS  = 3;
   localparam int MAX_DIGITS  = 11;
   localparam int DIGIT_FIELD = MAX_DIGITS * DIGIT_BITS;
   localparam int CNT_BITS    = $clog2(MAX_DIGITS + 1);
   localparam int CARRY_BITS  = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIGIT_BITS-1:0] TERMINATOR = 3'd7;

   typedef struct packed {
      logic [DIGIT_FIELD-1:0] digits;
      logic [MAX_DIGITS-1:0]  term_mask;
      logic [CNT_BITS-1:0]    count;
      logic                   eos;
   } ccd_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ccd_queue_ctl_type;

endpackage

[design/ccd_if.sv]
// request and response channel interfaces of the comma code decoder
interface ccd_req_if import ccd_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] word;
   logic                 end_of_stream;

   modport source (output valid, output word, output end_of_stream, input ready);
   modport sink (input valid, input word, input end_of_stream, output ready);
endinterface

interface ccd_rsp_if import ccd_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] value;
   logic                last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

[design/comma_code_decoder.sv]
// top level of the bijective base-7 comma code decoder
//
// req_chan carries 32-bit stream words, bit 0 first, with an end_of_stream
// flag; a request is taken when valid and ready are both high. rsp_chan
// returns one response per terminator digit (value and last), last set on
// the final response that a request causes; a word may cause none.
// The front end splits each word, with the bits carried from the previous
// one, into 10 or 11 digits and queues it; the queue holds two requests.
// The back end works one digit per cycle while the output register can take
// its responses, and loads the next queued word as it steps the final digit
// of the current one; the sustained rate is set by the back end's digit loop.
// A response passes from the queue through the back end's digit registers
// to the output register.
// When rsp_chan stalls, the back end halts at the next terminator, the
// queue fills and req_chan ready drops. Reset clears the partial value,
// the carried bits, the queue and the output valid flag.
module comma_code_decoder import ccd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ccd_req_if.sink   req_chan,
   ccd_rsp_if.source rsp_chan
);

   ccd_entry_type     front_entry, back_entry;
   ccd_queue_ctl_type queue_ctl;
   logic              accept, pop, full, empty;

   assign req_chan.ready = !full;
   assign accept         = req_chan.valid && !full;

   assign queue_ctl.push  = accept;
   assign queue_ctl.pop   = pop;

   ccd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .word          (req_chan.word),
      .end_of_stream (req_chan.end_of_stream),
      .entry         (front_entry)
   );

   ccd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_entry (front_entry),
      .rd_entry (back_entry),
      .ctl_in   (queue_ctl),
      .full     (full),
      .empty    (empty)
   );

   ccd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (back_entry),
      .entry_valid (!empty),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

[design/ccd_front.sv]
// front end: joins carried bits with each word, splits digits, marks terminators
module ccd_front import ccd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [WORD_BITS-1:0] word,
   input  logic          end_of_stream,
   output ccd_entry_type entry
);

   logic [CARRY_BITS-1:0]  carry_bits_ff, carry_bits_in;
   logic [1:0]             carry_count_ff, carry_count_in;
   logic [DIGIT_FIELD:0]   stream;

   always_comb begin
      stream         = '0;
      carry_bits_in  = '0;
      carry_count_in = '0;
      entry.count    = CNT_BITS'(MAX_DIGITS);
      case (carry_count_ff)
         2'd1: begin
            stream = {1'b0, word, carry_bits_ff[0]};
         end
         2'd2: begin
            stream            = {word, carry_bits_ff};
            carry_bits_in[0]  = word[WORD_BITS-1];
            carry_count_in    = 2'd1;
         end
         default: begin
            stream         = {2'b00, word};
            carry_bits_in  = word[WORD_BITS-1 -: CARRY_BITS];
            carry_count_in = 2'd2;
            entry.count    = CNT_BITS'(MAX_DIGITS - 1);
         end
      endcase
      if (end_of_stream) begin
         carry_bits_in  = '0;
         carry_count_in = '0;
      end
      entry.digits = stream[DIGIT_FIELD-1:0];
      entry.eos    = end_of_stream;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         entry.term_mask[i] = (stream[i*DIGIT_BITS +: DIGIT_BITS] == TERMINATOR) &&
                              (CNT_BITS'(i) < entry.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_bits_ff  <= '0;
         carry_count_ff <= '0;
      end else if (accept) begin
         carry_bits_ff  <= carry_bits_in;
         carry_count_ff <= carry_count_in;
      end
   end

endmodule

[design/ccd_queue.sv]
// short queue of classified words between front and back end
module ccd_queue import ccd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ccd_entry_type     wr_entry,
   output ccd_entry_type     rd_entry,
   input  ccd_queue_ctl_type ctl_in,
   output logic              full,
   output logic              empty
);

   ccd_entry_type           mem [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]    count_ff, count_in;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rd_entry = mem[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (ctl_in.push && !ctl_in.pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (!ctl_in.push && ctl_in.pop) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (ctl_in.push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (ctl_in.pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.push) begin
         mem[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

[design/ccd_back.sv]
// back end: one digit per cycle unless a terminator waits on a busy output, accumulates the value and emits responses
module ccd_back import ccd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ccd_entry_type entry,
   input  logic          entry_valid,
   output logic          pop,
   ccd_rsp_if.source     rsp_chan
);

   logic                   busy_ff, busy_in;
   logic [DIGIT_FIELD-1:0] digits_ff, digits_in;
   logic [MAX_DIGITS-1:0]  mask_ff, mask_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   eos_ff, eos_in;
   logic [VALUE_BITS-1:0]  partial_ff, partial_in;
   logic                   out_valid_ff, out_valid_in;
   logic [OUT_BITS-1:0]    out_value_ff, out_value_in;
   logic                   out_last_ff, out_last_in;
   logic [DIGIT_BITS-1:0]  digit;
   logic                   is_term, out_free, step, final_digit;

   assign digit       = digits_ff[DIGIT_BITS-1:0];
   assign is_term     = mask_ff[0];
   assign out_free    = !out_valid_ff || rsp_chan.ready;
   assign step        = busy_ff && (!is_term || out_free);
   assign final_digit = (count_ff == CNT_BITS'(1));
   assign pop         = entry_valid && (!busy_ff || (step && final_digit));

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.value = out_value_ff;
   assign rsp_chan.last  = out_last_ff;

   always_comb begin
      busy_in      = busy_ff;
      digits_in    = digits_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;
      eos_in       = eos_ff;
      partial_in   = partial_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         digits_in = digits_ff >> DIGIT_BITS;
         mask_in   = mask_ff >> 1;
         count_in  = count_ff - CNT_BITS'(1);
         if (is_term) begin
            out_valid_in = 1'b1;
            out_value_in = OUT_BITS'(partial_ff);
            out_last_in  = (mask_ff[MAX_DIGITS-1:1] == '0);
            partial_in   = '0;
         end else begin
            partial_in = (partial_ff << 3) - partial_ff + VALUE_BITS'(digit) +
                         VALUE_BITS'(1);
         end
         if (final_digit) begin
            busy_in = 1'b0;
            if (eos_ff) begin
               partial_in = '0;
            end
         end
      end
      if (pop) begin
         busy_in   = 1'b1;
         digits_in = entry.digits;
         mask_in   = entry.term_mask;
         count_in  = entry.count;
         eos_in    = entry.eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         partial_ff   <= '0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         partial_ff   <= partial_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
      digits_ff    <= digits_in;
      mask_ff      <= mask_in;
      eos_ff       <= eos_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

endmodule
